/* rtl/core/spq_pkg.sv */
package spq_pkg;

    // Queue geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths of one entry
    localparam int ID_W   = 15;
    localparam int PRIO_W = 16;
    localparam int ENTRY_W = ID_W + PRIO_W;
    localparam int OCC_W  = 5;

    // Request codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Read address select
    typedef enum logic [1:0] {
        RD_PREV = 2'd0,
        RD_CUR  = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic       capture;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_rd;
        logic       wr_new;
        logic       idx_inc;
        logic       idx_dec;
        logic       take_hit;
        logic       set_st;
        logic [1:0] st_code;
        logic       fill_dec;
        logic       load_out;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       is_full;
        logic       is_empty;
        logic       idx_zero;
        logic       idx_last;
        logic       rd_less;
        logic       rd_match;
        logic       out_free;
    } t_dp_stat;

endpackage

/* rtl/core/spq_req_if.sv */
interface spq_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [spq_pkg::ID_W-1:0]    task_id;
    logic signed [spq_pkg::PRIO_W-1:0] prio;

    modport source (output valid, output cmd, output task_id, output prio, input ready);
    modport sink   (input valid, input cmd, input task_id, input prio, output ready);
endinterface

/* rtl/core/spq_rsp_if.sv */
interface spq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [spq_pkg::ID_W-1:0]    id_out;
    logic signed [spq_pkg::PRIO_W-1:0] prio_out;
    logic [spq_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output status, output id_out, output prio_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input id_out, input prio_out,
                    input occupancy, output ready);
endinterface

/* rtl/core/spq_datapath.sv */
module spq_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spq_pkg::t_dp_cmd                   i_cmd,
    output spq_pkg::t_dp_stat                  o_stat,
    input  logic [1:0]                         i_req_cmd,
    input  logic [spq_pkg::ID_W-1:0]           i_req_id,
    input  logic signed [spq_pkg::PRIO_W-1:0]  i_req_prio,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic [spq_pkg::ID_W-1:0]           o_id,
    output logic signed [spq_pkg::PRIO_W-1:0]  o_prio,
    output logic [spq_pkg::OCC_W-1:0]          o_occ
);

    logic [spq_pkg::ENTRY_W-1:0]      r_mem [spq_pkg::DEPTH];
    logic [spq_pkg::ENTRY_W-1:0]      r_rd;
    logic [spq_pkg::CNT_W-1:0]        r_fill;
    logic [spq_pkg::IDX_W-1:0]        r_idx;
    logic [1:0]                       r_cmd;
    logic [spq_pkg::ID_W-1:0]         r_id;
    logic signed [spq_pkg::PRIO_W-1:0] r_prio;
    logic [1:0]                       r_res_st;
    logic [spq_pkg::ID_W-1:0]         r_res_id;
    logic [spq_pkg::PRIO_W-1:0]       r_res_prio;
    logic                             r_ov;
    logic [1:0]                       r_o_st;
    logic [spq_pkg::ID_W-1:0]         r_o_id;
    logic [spq_pkg::PRIO_W-1:0]       r_o_prio;
    logic [spq_pkg::OCC_W-1:0]        r_o_occ;
    logic [spq_pkg::IDX_W-1:0]        rd_addr;
    logic signed [spq_pkg::PRIO_W-1:0] rd_prio;
    logic [spq_pkg::ID_W-1:0]         rd_id;

    assign rd_prio = r_rd[spq_pkg::ENTRY_W-1:spq_pkg::ID_W];
    assign rd_id   = r_rd[spq_pkg::ID_W-1:0];

    // Pick the read address around the working index
    always_comb begin
        case (i_cmd.rd_sel)
            spq_pkg::RD_PREV: rd_addr = r_idx - spq_pkg::IDX_W'(1);
            spq_pkg::RD_NEXT: rd_addr = r_idx + spq_pkg::IDX_W'(1);
            default:          rd_addr = r_idx;
        endcase
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            r_mem[r_idx] <= {r_prio, r_id};
        end else if (i_cmd.wr_rd) begin
            r_mem[r_idx] <= r_rd;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Latch the request and the working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd      <= i_req_cmd;
            r_id       <= i_req_id;
            r_prio     <= i_req_prio;
            r_res_st   <= spq_pkg::ST_OK;
            r_res_id   <= '0;
            r_res_prio <= '0;
        end else if (i_cmd.wr_new) begin
            r_res_id   <= r_id;
            r_res_prio <= r_prio;
        end else if (i_cmd.take_hit) begin
            r_res_id   <= rd_id;
            r_res_prio <= rd_prio;
        end else if (i_cmd.set_st) begin
            r_res_st   <= i_cmd.st_code;
        end
    end

    // Advance the working index: insert starts at the tail, search at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= (i_req_cmd == spq_pkg::CMD_INSERT) ? spq_pkg::IDX_W'(r_fill) : '0;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - spq_pkg::IDX_W'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + spq_pkg::IDX_W'(1);
        end
    end

    // Track the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.wr_new) begin
            r_fill <= r_fill + spq_pkg::CNT_W'(1);
        end else if (i_cmd.fill_dec) begin
            r_fill <= r_fill - spq_pkg::CNT_W'(1);
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_st   <= r_res_st;
            r_o_id   <= r_res_id;
            r_o_prio <= r_res_prio;
            r_o_occ  <= spq_pkg::OCC_W'(r_fill);
        end
    end

    // Report status to the controller
    assign o_stat.cmd      = r_cmd;
    assign o_stat.is_full  = (r_fill == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign o_stat.is_empty = (r_fill == '0);
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.idx_last = (spq_pkg::CNT_W'(r_idx) + spq_pkg::CNT_W'(1)) >= r_fill;
    assign o_stat.rd_less  = rd_prio < r_prio;
    assign o_stat.rd_match = (r_cmd == spq_pkg::CMD_POP) || (rd_id == r_id);
    assign o_stat.out_free = !r_ov || i_ready;

    assign o_valid  = r_ov;
    assign o_status = r_o_st;
    assign o_id     = r_o_id;
    assign o_prio   = r_o_prio;
    assign o_occ    = r_o_occ;

endmodule

/* rtl/core/spq_ctrl.sv */
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_INS_RD   = 9'b000000100,
        S_INS_CMP  = 9'b000001000,
        S_INS_PUT  = 9'b000010000,
        S_SRCH_CMP = 9'b000100000,
        S_SHF_RD   = 9'b001000000,
        S_SHF_WR   = 9'b010000000,
        S_FIN      = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Decode state and status into datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = spq_pkg::RD_CUR;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.cmd) inside
                    spq_pkg::CMD_INSERT: begin
                        if (i_stat.is_full) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = spq_pkg::ST_FULL;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    spq_pkg::CMD_POP, spq_pkg::CMD_REMOVE: begin
                        if (i_stat.is_empty) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = spq_pkg::ST_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state = S_SRCH_CMP;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_INS_RD: begin
                if (i_stat.idx_zero) begin
                    n_state = S_INS_PUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = spq_pkg::RD_PREV;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // move the lower-priority neighbor one place toward the tail
                if (i_stat.rd_less) begin
                    o_cmd.wr_rd   = 1'b1;
                    o_cmd.idx_dec = 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_cmd.wr_new = 1'b1;
                n_state = S_FIN;
            end
            S_SRCH_CMP: begin
                if (i_stat.rd_match) begin
                    o_cmd.take_hit = 1'b1;
                    n_state = S_SHF_RD;
                end else if (i_stat.idx_last) begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = spq_pkg::ST_NOTFOUND;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = spq_pkg::RD_NEXT;
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SRCH_CMP;
                end
            end
            S_SHF_RD: begin
                // close the gap one entry at a time
                if (i_stat.idx_last) begin
                    o_cmd.fill_dec = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = spq_pkg::RD_NEXT;
                    n_state = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                o_cmd.wr_rd   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_SHF_RD;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/sorted_priority_task_queue.sv */
// Sorted priority queue of up to DEPTH task entries (15-bit id, signed 16-bit
// priority), highest priority at the head, ties in arrival order. One request
// (insert, pop head, remove by id) gives one result with status, id, priority and
// the new count. Requests are handled one at a time through an entry store with
// registered reads. An insert starts at the tail and moves each entry of lower
// priority one place toward the tail, stopping behind an entry of equal or higher
// priority; pop and remove search from the head and move the entries behind the
// match up one place; a remove that finds nothing reports not found after it has
// searched every entry. The next request can be taken in the cycle after the
// result is loaded. A finished result waits in an output register while the next
// request is processed; a request that finishes while the previous result is
// still unread waits until the sink takes it.
module sorted_priority_task_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    spq_pkg::t_dp_cmd  dp_cmd;
    spq_pkg::t_dp_stat dp_stat;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    spq_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_req_cmd  (i_req.cmd),
        .i_req_id   (i_req.task_id),
        .i_req_prio (i_req.prio),
        .o_valid    (o_rsp.valid),
        .i_ready    (o_rsp.ready),
        .o_status   (o_rsp.status),
        .o_id       (o_rsp.id_out),
        .o_prio     (o_rsp.prio_out),
        .o_occ      (o_rsp.occupancy)
    );

`ifndef ASSERT_OFF
    // One request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    // Count never exceeds the depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.occupancy <= spq_pkg::OCC_W'(spq_pkg::DEPTH)))
        else $error("occupancy above depth");

    // A dropped insert reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == spq_pkg::ST_FULL))
            |-> (o_rsp.occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH)))
        else $error("full status with queue not full");

    // Failed requests carry no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != spq_pkg::ST_OK))
            |-> ((o_rsp.id_out == '0) && (o_rsp.prio_out == '0)))
        else $error("entry fields set on a failed request");
`endif

endmodule
